// File: src/mbr_pec_pkg.sv
// ----------------------------------------------------------------------------
// mbr_pec_pkg
// Shared types, codes and helpers for the MBR partition entry checker.
// ----------------------------------------------------------------------------
package mbr_pec_pkg;

    // cylinder shift range and limit of the BIOS CHS cylinder field
    localparam int SHIFT_W   = 3;
    localparam int MAX_SHIFT = 4;
    localparam logic [15:0] CYL_LIMIT = 16'd1024;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CYLINDERS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_PATH   = 3'd5;

    // register reset values
    localparam logic [15:0] RST_CYLINDERS = 16'd1024;
    localparam logic [7:0]  RST_HEADS     = 8'd16;
    localparam logic [7:0]  RST_SECTORS   = 8'd63;

    // partition type codes
    localparam logic [7:0] KIND_EMPTY     = 8'h00;
    localparam logic [7:0] KIND_FAT32_LBA = 8'h0C;
    localparam logic [7:0] KIND_FAT16_LBA = 8'h0E;
    localparam logic [7:0] KIND_EXT_LBA   = 8'h0F;
    localparam logic [7:0] KIND_HID_LBA   = 8'h1C;

    // boot indicator bits that must be clear
    localparam logic [7:0] ACTIVE_RSVD_MASK = 8'h7f;

    // check result codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BAD_FLAG  = 3'd2,
        ST_START_CHS = 3'd3,
        ST_END_CHS   = 3'd4,
        ST_BOUNDS    = 3'd5
    } t_status;

    // drive geometry seen by the decode units
    typedef struct packed {
        logic [15:0]        cylinders;
        logic [7:0]         heads;
        logic [7:0]         sectors;
        logic [SHIFT_W-1:0] shift;
    } t_geom;

    // smallest shift that brings the cylinder count to the CHS limit, capped
    function automatic logic [SHIFT_W-1:0] f_cyl_shift(input logic [15:0] cyl);
        logic [SHIFT_W-1:0] s;
        s = SHIFT_W'(MAX_SHIFT);
        for (int k = MAX_SHIFT - 1; k >= 0; k--) begin
            if ((cyl >> k) <= CYL_LIMIT) begin
                s = SHIFT_W'(k);
            end
        end
        return s;
    endfunction

    // types addressed by LBA only, no CHS cross check
    function automatic logic f_lba_only(input logic [7:0] kind);
        return (kind == KIND_FAT32_LBA) || (kind == KIND_FAT16_LBA) ||
               (kind == KIND_EXT_LBA)   || (kind == KIND_HID_LBA);
    endfunction

endpackage

// File: src/mbr_pec_chs_lba.sv
// ----------------------------------------------------------------------------
// mbr_pec_chs_lba
// Four stage CHS to LBA decoder: shift, head multiply, sector multiply, add.
// ----------------------------------------------------------------------------
module mbr_pec_chs_lba
    import mbr_pec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_geom       i_geom,
    input  logic [7:0]  i_head,
    input  logic [7:0]  i_sector_cylhi,
    input  logic [7:0]  i_cyl_low,
    output logic [31:0] o_lba
);

    logic [13:0] r_cyl;
    logic [7:0]  r_head1;
    logic [5:0]  r_sec1;
    logic [21:0] r_v1;
    logic [7:0]  r_head2;
    logic [5:0]  r_sec2;
    logic [30:0] r_v2;
    logic [5:0]  r_sec3;
    logic [31:0] r_lba;

    logic [13:0] n_cyl;
    logic [21:0] n_v1;
    logic [22:0] w_sum;
    logic [30:0] n_v2;
    logic [31:0] n_lba;

    // stage 1: ten bit cylinder, scaled by the drive shift
    assign n_cyl = {4'b0, i_sector_cylhi[7:6], i_cyl_low} << i_geom.shift;
    // stage 2: cylinder times heads
    assign n_v1  = {8'b0, r_cyl} * {14'b0, i_geom.heads};
    // stage 3: add head, times sectors per track
    assign w_sum = {1'b0, r_v1} + {15'b0, r_head2};
    assign n_v2  = {8'b0, w_sum} * {23'b0, i_geom.sectors};
    // stage 4: add one-based sector, wraps at 32 bits
    assign n_lba = {1'b0, r_v2} + {26'b0, r_sec3} - 32'd1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cyl   <= n_cyl;
            r_head1 <= i_head;
            r_sec1  <= i_sector_cylhi[5:0];
            r_v1    <= n_v1;
            r_head2 <= r_head1;
            r_sec2  <= r_sec1;
            r_v2    <= n_v2;
            r_sec3  <= r_sec2;
            r_lba   <= n_lba;
        end
    end

    assign o_lba = r_lba;

endmodule

// File: src/mbr_pec_max_lba.sv
// ----------------------------------------------------------------------------
// mbr_pec_max_lba
// Four stage computation of the largest LBA reachable through CHS.
// ----------------------------------------------------------------------------
module mbr_pec_max_lba
    import mbr_pec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_geom       i_geom,
    output logic [31:0] o_max_lba
);

    logic [10:0] r_cyls;
    logic [18:0] r_m1;
    logic [26:0] r_m2;
    logic [31:0] r_max;

    logic [15:0] w_shifted;
    logic [10:0] n_cyls;
    logic [18:0] n_m1;
    logic [26:0] n_m2;
    logic [31:0] n_max;

    // stage 1: shifted cylinder count, clamped to the CHS limit
    assign w_shifted = i_geom.cylinders >> i_geom.shift;
    assign n_cyls    = (w_shifted > CYL_LIMIT) ? CYL_LIMIT[10:0] : w_shifted[10:0];
    // stage 2 and 3: cylinders times heads times sectors
    assign n_m1 = {8'b0, r_cyls} * {11'b0, i_geom.heads};
    assign n_m2 = {8'b0, r_m1} * {19'b0, i_geom.sectors};
    // stage 4: undo the shift, last sector index wraps when empty
    assign n_max = ({5'b0, r_m2} << i_geom.shift) - 32'd1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cyls <= n_cyls;
            r_m1   <= n_m1;
            r_m2   <= n_m2;
            r_max  <= n_max;
        end
    end

    assign o_max_lba = r_max;

endmodule

// File: src/mbr_partition_entry_check.sv
// Throughput: one transaction per cycle; the five stage pipeline advances as
// a whole and holds only while the output register is full and stalled.
// Reset (synchronous, active low) empties the pipeline and loads the default
// geometry (1024 cylinders, 16 heads, 63 sectors) and a zero parent.
// ----------------------------------------------------------------------------
// mbr_partition_entry_check
// Checks one MBR partition entry against drive geometry and parent bounds.
// ----------------------------------------------------------------------------
module mbr_partition_entry_check
    import mbr_pec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // entry input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_entry_index,
    input  logic [7:0]           i_active_byte,
    input  logic [7:0]           i_start_head,
    input  logic [7:0]           i_start_sector_cylhi,
    input  logic [7:0]           i_start_cyl_low,
    input  logic [7:0]           i_part_kind,
    input  logic [7:0]           i_end_head,
    input  logic [7:0]           i_end_sector_cylhi,
    input  logic [7:0]           i_end_cyl_low,
    input  logic [31:0]          i_relative_start,
    input  logic [31:0]          i_sector_total,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    output logic [31:0]          o_absolute_start,
    output logic [31:0]          o_length_out,
    output logic [29:0]          o_child_path,
    output logic [7:0]           o_kind_out
);

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] end_lba;
        logic [31:0] count;
        logic [7:0]  kind;
        logic [29:0] path;
        logic        empty;
        logic        bad_flag;
        logic        lba_only;
        logic        below;
        logic        over;
    } t_item;

    // configuration registers
    logic [15:0] r_cylinders;
    logic [7:0]  r_heads;
    logic [7:0]  r_sectors;
    logic [31:0] r_parent_start;
    logic [31:0] r_parent_length;
    logic [26:0] r_parent_path;

    // pipeline
    logic [4:0]  r_vld;
    t_item       r_s1, r_s2, r_s3, r_s4;
    t_item       n_s1, n_s2, n_s3;
    t_status     r_status, n_status;
    logic [31:0] r_start_out;
    logic [31:0] r_length_out;
    logic [29:0] r_path_out;
    logic [7:0]  r_kind_out;

    logic        w_adv;
    t_geom       w_geom;
    logic [30:0] w_path_sum;
    logic [31:0] w_limit;
    logic [31:0] w_chs_start;
    logic [31:0] w_chs_end;
    logic [31:0] w_max_lba;
    logic [31:0] w_min_start;
    logic [31:0] w_min_end;

    // whole pipeline moves unless a finished result is held back
    assign w_adv      = !(r_vld[4] && i_out_stall);
    assign o_in_stall = !w_adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cylinders     <= RST_CYLINDERS;
            r_heads         <= RST_HEADS;
            r_sectors       <= RST_SECTORS;
            r_parent_start  <= '0;
            r_parent_length <= '0;
            r_parent_path   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CYLINDERS:     r_cylinders     <= i_cfg_data[15:0];
                CFG_HEADS:         r_heads         <= i_cfg_data[7:0];
                CFG_SECTORS:       r_sectors       <= i_cfg_data[7:0];
                CFG_PARENT_START:  r_parent_start  <= i_cfg_data;
                CFG_PARENT_LENGTH: r_parent_length <= i_cfg_data;
                CFG_PARENT_PATH:   r_parent_path   <= i_cfg_data[26:0];
                default: ;
            endcase
        end
    end

    // geometry bundle for the decode units
    always_comb begin
        w_geom.cylinders = r_cylinders;
        w_geom.heads     = r_heads;
        w_geom.sectors   = r_sectors;
        w_geom.shift     = f_cyl_shift(r_cylinders);
    end

    // stage 1: absolute start, child path, type and flag checks
    assign w_path_sum = ({4'b0, r_parent_path} << 3) + ({4'b0, r_parent_path} << 1)
                      + {29'b0, i_entry_index} + 31'd1;
    always_comb begin
        n_s1          = '0;
        n_s1.start    = r_parent_start + i_relative_start;
        n_s1.count    = i_sector_total;
        n_s1.kind     = i_part_kind;
        n_s1.path     = w_path_sum[29:0];
        n_s1.empty    = (i_part_kind == KIND_EMPTY);
        n_s1.bad_flag = (i_active_byte & ACTIVE_RSVD_MASK) != 8'h00;
        n_s1.lba_only = f_lba_only(i_part_kind);
    end

    // stage 2: last sector and lower bound
    always_comb begin
        n_s2         = r_s1;
        n_s2.end_lba = r_s1.start + r_s1.count - 32'd1;
        n_s2.below   = r_s1.start < r_parent_start;
    end

    // stage 3: upper bound against the parent end, wraps at 32 bits
    assign w_limit = r_parent_start + r_parent_length;
    always_comb begin
        n_s3      = r_s2;
        n_s3.over = r_s2.end_lba >= w_limit;
    end

    // stage 5: clamp to CHS reach and resolve status in check order
    assign w_min_start = (r_s4.start < w_max_lba) ? r_s4.start : w_max_lba;
    assign w_min_end   = (r_s4.end_lba < w_max_lba) ? r_s4.end_lba : w_max_lba;
    always_comb begin
        if (r_s4.empty) begin
            n_status = ST_EMPTY;
        end else if (r_s4.bad_flag) begin
            n_status = ST_BAD_FLAG;
        end else if (!r_s4.lba_only && (w_min_start != w_chs_start)) begin
            n_status = ST_START_CHS;
        end else if (!r_s4.lba_only && (w_min_end != w_chs_end)) begin
            n_status = ST_END_CHS;
        end else if (r_s4.below || r_s4.over) begin
            n_status = ST_BOUNDS;
        end else begin
            n_status = ST_OK;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], i_in_valid};
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1         <= n_s1;
            r_s2         <= n_s2;
            r_s3         <= n_s3;
            r_s4         <= r_s3;
            r_status     <= n_status;
            r_start_out  <= r_s4.start;
            r_length_out <= (n_status == ST_OK) ? r_s4.count : 32'd0;
            r_path_out   <= r_s4.path;
            r_kind_out   <= r_s4.kind;
        end
    end

    // start and end CHS decoders, CHS reach
    mbr_pec_chs_lba u_chs_start (
        .i_clk          (i_clk),
        .i_en           (w_adv),
        .i_geom         (w_geom),
        .i_head         (i_start_head),
        .i_sector_cylhi (i_start_sector_cylhi),
        .i_cyl_low      (i_start_cyl_low),
        .o_lba          (w_chs_start)
    );

    mbr_pec_chs_lba u_chs_end (
        .i_clk          (i_clk),
        .i_en           (w_adv),
        .i_geom         (w_geom),
        .i_head         (i_end_head),
        .i_sector_cylhi (i_end_sector_cylhi),
        .i_cyl_low      (i_end_cyl_low),
        .o_lba          (w_chs_end)
    );

    mbr_pec_max_lba u_max_lba (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_geom    (w_geom),
        .o_max_lba (w_max_lba)
    );

    // outputs
    assign o_out_valid      = r_vld[4];
    assign o_status         = r_status;
    assign o_absolute_start = r_start_out;
    assign o_length_out     = r_length_out;
    assign o_child_path     = r_path_out;
    assign o_kind_out       = r_kind_out;

    // a stall freezes the valid bits
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    // an empty type always reports empty
    a_empty_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind_out == KIND_EMPTY) |-> (o_status == ST_EMPTY))
        else $error("empty entry not reported as empty");

    // rejected entries carry no length
    a_reject_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_length_out == 32'd0))
        else $error("rejected entry with nonzero length");

    // an accepted entry never starts before its parent
    a_ok_in_parent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |-> (o_absolute_start >= r_parent_start))
        else $error("accepted entry starts before its parent");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MBR partition entry checker. A local predictor
// works out status, absolute start, length, child path and echoed type for
// every accepted entry transaction; a monitor compares each result in order.
// Directed corner entries come first, then randomized entries under a sweep
// of drive geometries and parent bounds, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import mbr_pec_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_PAUSE    = 8;
    localparam int SWEEP_PHASES   = 9;
    localparam int SWEEP_ITEMS    = 145;
    localparam int RATE_ITEMS     = 130;
    localparam int MAX_PRINTS     = 30;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // one partition table entry
    typedef struct {
        bit [1:0]  slot;
        bit [7:0]  boot;
        bit [7:0]  s_head;
        bit [7:0]  s_sec;
        bit [7:0]  s_cyl;
        bit [7:0]  kind;
        bit [7:0]  e_head;
        bit [7:0]  e_sec;
        bit [7:0]  e_cyl;
        bit [31:0] rel;
        bit [31:0] count;
    } t_entry;

    // predicted verdict for one entry
    typedef struct {
        t_status   status;
        bit [31:0] abs_start;
        bit [31:0] length;
        bit [29:0] path;
        bit [7:0]  kind;
    } t_verdict;

    // dut ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_entry_index = '0;
    logic [7:0]           i_active_byte = '0;
    logic [7:0]           i_start_head = '0;
    logic [7:0]           i_start_sector_cylhi = '0;
    logic [7:0]           i_start_cyl_low = '0;
    logic [7:0]           i_part_kind = '0;
    logic [7:0]           i_end_head = '0;
    logic [7:0]           i_end_sector_cylhi = '0;
    logic [7:0]           i_end_cyl_low = '0;
    logic [31:0]          i_relative_start = '0;
    logic [31:0]          i_sector_total = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [2:0]           o_status;
    logic [31:0]          o_absolute_start;
    logic [31:0]          o_length_out;
    logic [29:0]          o_child_path;
    logic [7:0]           o_kind_out;

    // mirror of the configuration registers
    bit [15:0] geo_cyl;
    bit [7:0]  geo_heads;
    bit [7:0]  geo_spt;
    bit [31:0] par_start;
    bit [31:0] par_len;
    bit [26:0] par_path;

    t_verdict pending_verdicts[$];
    t_verdict head_verdict;
    bit       bursts_on = 1'b0;
    int       stall_left = 0;
    int       quiet_cycles = 0;
    int       mismatches = 0;
    int       items_sent = 0;
    int       results_checked = 0;
    int       settings_applied = 0;
    int       status_seen[6];

    mbr_partition_entry_check i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_entry_index        (i_entry_index),
        .i_active_byte        (i_active_byte),
        .i_start_head         (i_start_head),
        .i_start_sector_cylhi (i_start_sector_cylhi),
        .i_start_cyl_low      (i_start_cyl_low),
        .i_part_kind          (i_part_kind),
        .i_end_head           (i_end_head),
        .i_end_sector_cylhi   (i_end_sector_cylhi),
        .i_end_cyl_low        (i_end_cyl_low),
        .i_relative_start     (i_relative_start),
        .i_sector_total       (i_sector_total),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_absolute_start     (o_absolute_start),
        .o_length_out         (o_length_out),
        .o_child_path         (o_child_path),
        .o_kind_out           (o_kind_out)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // shift that folds the cylinder count into the 1024 cylinder CHS range
    function automatic int unsigned cyl_shift_of();
        int unsigned s;
        s = 0;
        while (((geo_cyl >> s) > CYL_LIMIT) && (s < MAX_SHIFT)) s++;
        return s;
    endfunction

    // cylinder count after the shift, capped at the CHS limit
    function automatic bit [31:0] usable_cyls();
        bit [31:0] n;
        n = {16'd0, geo_cyl} >> cyl_shift_of();
        if (n > {16'd0, CYL_LIMIT}) n = {16'd0, CYL_LIMIT};
        return n;
    endfunction

    // highest lba that a CHS address can reach, wraps to all ones on zero geometry
    function automatic bit [31:0] chs_max();
        bit [31:0] prod;
        prod = usable_cyls() * {24'd0, geo_heads} * {24'd0, geo_spt};
        return (prod << cyl_shift_of()) - 32'd1;
    endfunction

    // CHS bytes to lba, 32 bit wrap throughout
    function automatic bit [31:0] chs_lba(input bit [7:0] hd, input bit [7:0] sb,
                                          input bit [7:0] cl);
        bit [31:0] cyl;
        bit [31:0] acc;
        cyl = {22'd0, sb[7:6], cl};
        acc = (cyl << cyl_shift_of()) * {24'd0, geo_heads};
        acc = (acc + {24'd0, hd}) * {24'd0, geo_spt};
        return acc + {26'd0, sb[5:0]} - 32'd1;
    endfunction

    function automatic bit lba_kind(input bit [7:0] kind);
        case (kind)
            KIND_FAT32_LBA, KIND_FAT16_LBA, KIND_EXT_LBA, KIND_HID_LBA: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // full verdict for one entry under the current register mirror
    function automatic t_verdict judge_entry(input t_entry e);
        t_verdict  v;
        bit [31:0] first_lba;
        bit [31:0] last_lba;
        bit [31:0] top;
        bit [31:0] parent_end;
        bit [31:0] path_acc;
        first_lba  = par_start + e.rel;
        last_lba   = first_lba + e.count - 32'd1;
        top        = chs_max();
        parent_end = par_start + par_len;
        if (e.kind == KIND_EMPTY) begin
            v.status = ST_EMPTY;
        end else if ((e.boot & ACTIVE_RSVD_MASK) != 8'd0) begin
            v.status = ST_BAD_FLAG;
        end else if (!lba_kind(e.kind) && ((first_lba < top) ? first_lba : top) !=
                     chs_lba(e.s_head, e.s_sec, e.s_cyl)) begin
            v.status = ST_START_CHS;
        end else if (!lba_kind(e.kind) && ((last_lba < top) ? last_lba : top) !=
                     chs_lba(e.e_head, e.e_sec, e.e_cyl)) begin
            v.status = ST_END_CHS;
        end else if (first_lba < par_start || last_lba >= parent_end) begin
            v.status = ST_BOUNDS;
        end else begin
            v.status = ST_OK;
        end
        path_acc    = {5'd0, par_path} * 32'd10 + {30'd0, e.slot} + 32'd1;
        v.abs_start = first_lba;
        v.length    = (v.status == ST_OK) ? e.count : 32'd0;
        v.path      = path_acc[29:0];
        v.kind      = e.kind;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // entry builders
    // ------------------------------------------------------------------

    // entry whose relative start and count agree with its CHS addresses
    function automatic t_entry fit_entry(input bit [1:0] slot, input bit [7:0] boot,
                                         input bit [7:0] kind,
                                         input bit [9:0] c0, input bit [7:0] h0,
                                         input bit [5:0] s0,
                                         input bit [9:0] c1, input bit [7:0] h1,
                                         input bit [5:0] s1);
        t_entry    e;
        bit [31:0] lo;
        bit [31:0] hi;
        e.slot   = slot;
        e.boot   = boot;
        e.kind   = kind;
        e.s_head = h0;
        e.s_sec  = {c0[9:8], s0};
        e.s_cyl  = c0[7:0];
        e.e_head = h1;
        e.e_sec  = {c1[9:8], s1};
        e.e_cyl  = c1[7:0];
        lo       = chs_lba(e.s_head, e.s_sec, e.s_cyl);
        hi       = chs_lba(e.e_head, e.e_sec, e.e_cyl);
        e.rel    = lo - par_start;
        e.count  = hi - lo + 32'd1;
        return e;
    endfunction

    // random entry: mostly consistent ones, some broken ones and raw noise
    function automatic t_entry gen_item();
        t_entry      e;
        int unsigned pick;
        int unsigned ncyl;
        int unsigned nh;
        int unsigned ns;
        int unsigned bitpos;
        bit [9:0]    c0, c1, ct;
        bit [7:0]    h0, h1, ht;
        bit [5:0]    s0, s1, st;
        bit [31:0]   top;
        bit [31:0]   extra;
        bit [7:0]    kind;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            e.slot   = 2'($urandom());
            e.boot   = 8'($urandom());
            e.s_head = 8'($urandom());
            e.s_sec  = 8'($urandom());
            e.s_cyl  = 8'($urandom());
            e.kind   = 8'($urandom());
            e.e_head = 8'($urandom());
            e.e_sec  = 8'($urandom());
            e.e_cyl  = 8'($urandom());
            e.rel    = $urandom();
            e.count  = $urandom();
            return e;
        end
        ncyl = usable_cyls();
        if (ncyl == 0) ncyl = 1024;
        nh = (geo_heads == 8'd0) ? 256 : geo_heads;
        ns = (geo_spt == 8'd0 || geo_spt > 8'd63) ? 63 : geo_spt;
        c0 = 10'($urandom_range(0, ncyl - 1));
        h0 = 8'($urandom_range(0, nh - 1));
        s0 = 6'($urandom_range(1, ns));
        c1 = 10'($urandom_range(0, ncyl - 1));
        h1 = 8'($urandom_range(0, nh - 1));
        s1 = 6'($urandom_range(1, ns));
        if ($urandom_range(0, 7) == 0) begin
            c0 = 10'(ncyl - 1); h0 = 8'(nh - 1); s0 = 6'(ns);
        end
        if ($urandom_range(0, 3) == 0) begin
            c1 = 10'(ncyl - 1); h1 = 8'(nh - 1); s1 = 6'(ns);
        end
        // keep the end address at or after the start
        if (chs_lba(h1, {c1[9:8], s1}, c1[7:0]) < chs_lba(h0, {c0[9:8], s0}, c0[7:0])) begin
            ct = c0; ht = h0; st = s0;
            c0 = c1; h0 = h1; s0 = s1;
            c1 = ct; h1 = ht; s1 = st;
        end
        kind = 8'($urandom_range(1, 255));
        if (lba_kind(kind)) kind = 8'h83;
        e = fit_entry(2'($urandom()), $urandom_range(0, 1) ? 8'h80 : 8'h00, kind,
                      c0, h0, s0, c1, h1, s1);
        // addresses at the CHS ceiling may sit anywhere above it
        top = chs_max();
        if (chs_lba(e.s_head, e.s_sec, e.s_cyl) == top) begin
            extra   = $urandom_range(0, 5000);
            e.rel   = e.rel + extra;
            e.count = e.count - extra;
        end
        if (chs_lba(e.e_head, e.e_sec, e.e_cyl) == top) begin
            e.count = e.count + $urandom_range(0, 5000);
        end
        if (pick >= 75 && pick < 85) begin
            case ($urandom_range(0, 3))
                0: e.kind = KIND_FAT32_LBA;
                1: e.kind = KIND_FAT16_LBA;
                2: e.kind = KIND_EXT_LBA;
                default: e.kind = KIND_HID_LBA;
            endcase
            e.rel   = $urandom_range(0, 32'h0010_0000);
            e.count = $urandom_range(0, 32'h0010_0000);
        end else if (pick >= 85) begin
            bitpos = $urandom_range(0, 7);
            case ($urandom_range(0, 6))
                0: e.s_head = e.s_head ^ 8'(1 << bitpos);
                1: e.s_sec  = e.s_sec  ^ 8'(1 << bitpos);
                2: e.s_cyl  = e.s_cyl  ^ 8'(1 << bitpos);
                3: e.e_head = e.e_head ^ 8'(1 << bitpos);
                4: e.e_sec  = e.e_sec  ^ 8'(1 << bitpos);
                5: e.e_cyl  = e.e_cyl  ^ 8'(1 << bitpos);
                default: e.boot = e.boot ^ 8'(1 << bitpos);
            endcase
        end
        return e;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // send one entry transaction, with an optional idle burst ahead of it
    task automatic send_entry(input t_entry e);
        int n;
        @(negedge i_clk);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_entry_index        <= e.slot;
        i_active_byte        <= e.boot;
        i_start_head         <= e.s_head;
        i_start_sector_cylhi <= e.s_sec;
        i_start_cyl_low      <= e.s_cyl;
        i_part_kind          <= e.kind;
        i_end_head           <= e.e_head;
        i_end_sector_cylhi   <= e.e_sec;
        i_end_cyl_low        <= e.e_cyl;
        i_relative_start     <= e.rel;
        i_sector_total       <= e.count;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        pending_verdicts.push_back(judge_entry(e));
        items_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // wait for every pending result, then let the pipeline settle
    task automatic wait_drained();
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CYLINDERS:     geo_cyl   = data[15:0];
            CFG_HEADS:         geo_heads = data[7:0];
            CFG_SECTORS:       geo_spt   = data[7:0];
            CFG_PARENT_START:  par_start = data;
            CFG_PARENT_LENGTH: par_len   = data;
            CFG_PARENT_PATH:   par_path  = data[26:0];
            default: ;
        endcase
    endtask

    // idle the block and load a full register set, junk in the unused upper bits
    task automatic load_config(input bit [15:0] cyl, input bit [7:0] heads,
                               input bit [7:0] spt, input bit [31:0] pstart,
                               input bit [31:0] plen, input bit [31:0] path_raw);
        bit [31:0] junk;
        release_input();
        wait_drained();
        junk = $urandom();
        write_reg(CFG_CYLINDERS, {junk[31:16], cyl});
        write_reg(CFG_HEADS, {junk[31:8], heads});
        write_reg(CFG_SECTORS, {junk[23:0], spt});
        write_reg(CFG_PARENT_START, pstart);
        write_reg(CFG_PARENT_LENGTH, plen);
        write_reg(CFG_PARENT_PATH, path_raw);
        write_reg(CFG_SPARE_A, $urandom());
        write_reg(CFG_SPARE_B, $urandom());
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic load_random_config();
        bit [15:0] cyl;
        bit [31:0] pstart;
        bit [31:0] plen;
        bit [31:0] junk;
        cyl    = $urandom_range(0, 2) == 0 ? 16'($urandom()) : 16'($urandom_range(1, 1024));
        pstart = $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 32'h0001_0000);
        plen   = $urandom_range(0, 3) == 0 ? $urandom() : 32'hFFFF_FFFF - pstart;
        junk   = $urandom();
        load_config(cyl, 8'($urandom_range(1, 255)),
                    $urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
                                              : 8'($urandom_range(1, 63)),
                    pstart, plen, {junk[31:27], 27'($urandom_range(0, 99999999))});
    endtask

    // random result side stall bursts
    always @(negedge i_clk) begin
        if (!bursts_on || !i_rst_n) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: mismatch in %s, got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // compare each result transaction with the oldest pending verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch("result with no entry pending", {29'd0, o_status}, 32'd0);
            end else begin
                head_verdict = pending_verdicts.pop_front();
                results_checked++;
                if (o_status < 3'd6) status_seen[o_status]++;
                if (o_status !== head_verdict.status)
                    flag_mismatch("status", {29'd0, o_status}, {29'd0, head_verdict.status});
                if (o_absolute_start !== head_verdict.abs_start)
                    flag_mismatch("absolute start", o_absolute_start, head_verdict.abs_start);
                if (o_length_out !== head_verdict.length)
                    flag_mismatch("length", o_length_out, head_verdict.length);
                if (o_child_path !== head_verdict.path)
                    flag_mismatch("child path", {2'd0, o_child_path}, {2'd0, head_verdict.path});
                if (o_kind_out !== head_verdict.kind)
                    flag_mismatch("kind", {24'd0, o_kind_out}, {24'd0, head_verdict.kind});
            end
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                     i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // entries against the register values left by reset
    task automatic test_reset_state();
        t_entry e;
        e = fit_entry(2'd0, 8'h80, 8'h83, 10'd0, 8'd0, 6'd1, 10'd10, 8'd0, 6'd1);
        send_entry(e);
        e = fit_entry(2'd1, 8'h00, KIND_HID_LBA, 10'd0, 8'd0, 6'd1, 10'd0, 8'd0, 6'd1);
        send_entry(e);
        e = fit_entry(2'd2, 8'h00, KIND_EMPTY, 10'd3, 8'd1, 6'd2, 10'd4, 8'd1, 6'd2);
        send_entry(e);
    endtask

    // one entry per check, flag, type class and corner of the arithmetic
    task automatic test_directed_cases();
        t_entry   e;
        bit [7:0] lba_list[4];
        lba_list = '{KIND_FAT32_LBA, KIND_FAT16_LBA, KIND_EXT_LBA, KIND_HID_LBA};
        bursts_on = 1'b1;
        load_config(16'd1024, 8'd16, 8'd63, 32'h0000_0100, 32'hFFFF_FE00, 32'hFFFF_FFFF);
        // well formed entries, inactive and active
        send_entry(fit_entry(2'd0, 8'h00, 8'h83, 10'd5, 8'd3, 6'd1, 10'd9, 8'd15, 6'd63));
        send_entry(fit_entry(2'd1, 8'h80, 8'h07, 10'd0, 8'd1, 6'd1, 10'd1023, 8'd15, 6'd63));
        // empty type
        send_entry(fit_entry(2'd2, 8'h80, KIND_EMPTY, 10'd1, 8'd0, 6'd1, 10'd2, 8'd0, 6'd1));
        // reserved boot indicator bits
        send_entry(fit_entry(2'd3, 8'h01, 8'h83, 10'd1, 8'd0, 6'd1, 10'd2, 8'd0, 6'd1));
        send_entry(fit_entry(2'd0, 8'h7f, 8'h83, 10'd1, 8'd0, 6'd1, 10'd2, 8'd0, 6'd1));
        send_entry(fit_entry(2'd1, 8'hff, 8'h83, 10'd1, 8'd0, 6'd1, 10'd2, 8'd0, 6'd1));
        // lba only types skip the CHS cross check
        for (int k = 0; k < 4; k++) begin
            e = fit_entry(2'(k), 8'h00, lba_list[k], 10'd1, 8'd0, 6'd1, 10'd2, 8'd0, 6'd1);
            e.s_head = 8'hFF; e.s_sec = 8'hFF; e.s_cyl = 8'hFF;
            e.e_head = 8'hFF; e.e_sec = 8'hFF; e.e_cyl = 8'hFF;
            e.rel    = 32'h1000;
            e.count  = 32'h800;
            send_entry(e);
        end
        // start and end CHS disagreement
        e = fit_entry(2'd3, 8'h00, 8'h83, 10'd7, 8'd2, 6'd5, 10'd20, 8'd4, 6'd9);
        e.s_head = e.s_head ^ 8'h01;
        send_entry(e);
        e = fit_entry(2'd2, 8'h00, 8'h83, 10'd7, 8'd2, 6'd5, 10'd20, 8'd4, 6'd9);
        e.e_cyl = e.e_cyl ^ 8'h01;
        send_entry(e);
        // zero sector field, at the start and at the end
        send_entry(fit_entry(2'd0, 8'h00, 8'h83, 10'd0, 8'd0, 6'd0, 10'd4, 8'd0, 6'd1));
        send_entry(fit_entry(2'd1, 8'h00, 8'h83, 10'd3, 8'd0, 6'd1, 10'd5, 8'd0, 6'd0));
        // zero sector count wraps the end lba
        e = fit_entry(2'd2, 8'h00, KIND_FAT16_LBA, 10'd0, 8'd0, 6'd1, 10'd0, 8'd0, 6'd1);
        e.rel   = 32'd5;
        e.count = 32'd0;
        send_entry(e);
        // both addresses above the CHS ceiling
        e = fit_entry(2'd2, 8'h80, 8'h83, 10'd1023, 8'd15, 6'd63, 10'd1023, 8'd15, 6'd63);
        e.rel   = e.rel + 32'd1000;
        e.count = 32'd40;
        send_entry(e);
        // last sector of the parent, then one past it
        e = fit_entry(2'd3, 8'h00, KIND_EXT_LBA, 10'd0, 8'd0, 6'd1, 10'd0, 8'd0, 6'd1);
        e.rel   = 32'hFFFF_FD00;
        e.count = 32'h100;
        send_entry(e);
        e.count = 32'h101;
        send_entry(e);
        // start below the parent
        send_entry(fit_entry(2'd3, 8'h00, 8'h83, 10'd0, 8'd0, 6'd1, 10'd0, 8'd5, 6'd1));
        // all ones and all zeros
        e.slot = '1; e.boot = '1; e.s_head = '1; e.s_sec = '1; e.s_cyl = '1; e.kind = '1;
        e.e_head = '1; e.e_sec = '1; e.e_cyl = '1; e.rel = '1; e.count = '1;
        send_entry(e);
        e.slot = '0; e.boot = '0; e.s_head = '0; e.s_sec = '0; e.s_cyl = '0; e.kind = '0;
        e.e_head = '0; e.e_sec = '0; e.e_cyl = '0; e.rel = '0; e.count = '0;
        send_entry(e);
    endtask

    // random entries under a sweep of geometry and parent settings
    task automatic test_register_sweep();
        for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
            case (phase)
                0: load_config(16'd0, 8'd16, 8'd63, 32'd0, 32'hFFFF_FFFF, 32'd0);
                1: load_config(16'd1024, 8'd0, 8'd63, 32'd0, 32'hFFFF_FFFF, 32'd1);
                2: load_config(16'd1024, 8'd255, 8'd0, 32'd0, 32'hFFFF_FFFF, 32'd12345);
                3: load_config(16'hFFFF, 8'd255, 8'd255, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                4: load_config(16'd1, 8'd1, 8'd1, 32'hFFFF_FFFF, 32'd0, 32'd99999999);
                5: load_config(16'd1025, 8'd16, 8'd63, 32'd2048, 32'h1000_0000, 32'd7);
                6: load_config(16'd16383, 8'd255, 8'd63, 32'd0, $urandom(), 32'd4321);
                default: load_random_config();
            endcase
            bursts_on = ($urandom_range(0, 4) != 0);
            repeat (SWEEP_ITEMS) send_entry(gen_item());
        end
    endtask

    // back to back entries with no gaps or stalls
    task automatic test_full_rate();
        load_random_config();
        bursts_on = 1'b0;
        repeat (RATE_ITEMS) send_entry(gen_item());
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        geo_cyl   = RST_CYLINDERS;
        geo_heads = RST_HEADS;
        geo_spt   = RST_SECTORS;
        par_start = '0;
        par_len   = '0;
        par_path  = '0;
        foreach (status_seen[k]) status_seen[k] = 0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_cases();
        test_register_sweep();
        test_full_rate();

        release_input();
        wait_drained();
        $display("covered %0d entries under %0d register settings, %0d results checked",
                 items_sent, settings_applied, results_checked);
        $display("statuses: ok %0d, empty %0d, flag %0d, start chs %0d, end chs %0d, bounds %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/mbr_pec_pkg.sv
src/mbr_pec_chs_lba.sv
src/mbr_pec_max_lba.sv
src/mbr_partition_entry_check.sv
bench/tb_top.sv
